// ===== hdl/scb_pkg.sv =====
// shared types and constants for the status byte control parser
`default_nettype none

package scb_pkg;

  // status byte codes
  localparam logic [7:0] STATUS_PRESS   = 8'd128;
  localparam logic [7:0] STATUS_RELEASE = 8'd129;
  localparam logic [7:0] STATUS_TEMPO   = 8'd130;

  // event kinds on the result word
  localparam logic EVENT_BUTTON = 1'b0;
  localparam logic EVENT_TEMPO  = 1'b1;

  // button levels
  localparam logic LEVEL_PRESS   = 1'b0;
  localparam logic LEVEL_RELEASE = 1'b1;

  // data count saturation point
  localparam logic [1:0] COUNT_MAX = 2'd3;

  typedef enum logic [1:0] {
    MSG_IGNORED = 2'd0,
    MSG_PRESS   = 2'd1,
    MSG_RELEASE = 2'd2,
    MSG_TEMPO   = 2'd3
  } msg_t;

  typedef struct packed {
    msg_t        msg;
    logic [1:0]  count;
    logic [13:0] accum;
  } parse_state_t;

  typedef struct packed {
    logic        event_kind;
    logic [6:0]  button_index;
    logic        button_level;
    logic [13:0] tempo_whole;
    logic [6:0]  tempo_hundredths;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/status_byte_control_parser_unit.sv =====
// top level: input register, byte decode, parser state and result register
//
//   channel  handshake            payload
//   input    in_valid / in_ready  rx_byte
//   output   out_valid/ out_ready event_kind, button_index, button_level,
//                                 tempo_whole, tempo_hundredths
//
// one word per cycle unless the output stalls; a byte is registered on acceptance,
// decoded from the input register, and its result, if any, loads the result register
// reset clears the parser state to the ignored message with zero count and accum
// the decode stage moves only while the result register is empty or being taken,
// so a stalled output holds both stages and in_ready drops once both are full
`default_nettype none

module status_byte_control_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             event_kind,
  output logic [6:0]       button_index,
  output logic             button_level,
  output logic [13:0]      tempo_whole,
  output logic [6:0]       tempo_hundredths
);

  logic                  byte_valid;
  logic [7:0]            byte_reg;
  logic                  advance;
  scb_pkg::parse_state_t state;
  scb_pkg::parse_state_t state_next;
  logic                  emit;
  scb_pkg::result_t      result_next;
  scb_pkg::result_t      result;

  // decode stage moves when the result register can take a word
  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_reg <= rx_byte;
    end
  end

  scb_decode u_decode (
    .rx_byte    (byte_reg),
    .state_cur  (state),
    .state_next (state_next),
    .emit       (emit),
    .result     (result_next)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{msg: scb_pkg::MSG_IGNORED, count: 2'd0, accum: 14'd0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      result <= result_next;
    end
  end

  assign event_kind       = result.event_kind;
  assign button_index     = result.button_index;
  assign button_level     = result.button_level;
  assign tempo_whole      = result.tempo_whole;
  assign tempo_hundredths = result.tempo_hundredths;

endmodule

`default_nettype wire

// ===== hdl/scb_decode.sv =====
// per-byte decode: next parser state and the optional result word
`default_nettype none

module scb_decode (
  input  wire logic [7:0]           rx_byte,
  input  wire scb_pkg::parse_state_t state_cur,
  output scb_pkg::parse_state_t      state_next,
  output logic                       emit,
  output scb_pkg::result_t           result
);

  logic [1:0] count_inc;
  logic [6:0] data;

  assign data      = rx_byte[6:0];
  assign count_inc = (state_cur.count == scb_pkg::COUNT_MAX) ? state_cur.count
                                                             : state_cur.count + 2'd1;

  always_comb begin
    state_next = state_cur;
    emit       = 1'b0;
    result     = '0;
    if (rx_byte[7]) begin
      // status byte: pick message, clear the data count
      unique case (rx_byte)
        scb_pkg::STATUS_PRESS:   state_next.msg = scb_pkg::MSG_PRESS;
        scb_pkg::STATUS_RELEASE: state_next.msg = scb_pkg::MSG_RELEASE;
        scb_pkg::STATUS_TEMPO:   state_next.msg = scb_pkg::MSG_TEMPO;
        default:                 state_next.msg = scb_pkg::MSG_IGNORED;
      endcase
      state_next.count = 2'd0;
    end else begin
      // data byte: count it, then act on the current message
      state_next.count = count_inc;
      unique case (state_cur.msg)
        scb_pkg::MSG_PRESS, scb_pkg::MSG_RELEASE: begin
          emit                = 1'b1;
          result.event_kind   = scb_pkg::EVENT_BUTTON;
          result.button_index = data;
          result.button_level = (state_cur.msg == scb_pkg::MSG_RELEASE)
                                ? scb_pkg::LEVEL_RELEASE : scb_pkg::LEVEL_PRESS;
        end
        scb_pkg::MSG_TEMPO: begin
          if (count_inc == 2'd1) begin
            // high seven bits of the whole tempo
            state_next.accum = {data, 7'd0};
          end else if (count_inc == 2'd2) begin
            state_next.accum = state_cur.accum + {7'd0, data};
          end else begin
            emit                    = 1'b1;
            result.event_kind       = scb_pkg::EVENT_TEMPO;
            result.tempo_whole      = state_cur.accum;
            result.tempo_hundredths = data;
          end
        end
        default: begin
          // ignored message: counted only
        end
      endcase
    end
  end

endmodule

`default_nettype wire
